// ===== rtl/dmcmc_pkg.sv =====
package dmcmc_pkg;

  // Field and storage widths
  localparam int ADDR_W     = 26;
  localparam int LINE_W     = 16;
  localparam int LINES      = 65536;
  localparam int LCNT_W     = 17;
  localparam int CNT_W      = 32;
  localparam int OFF_W      = 4;
  localparam int IDXB_W     = 5;
  localparam int SHIFT_W    = 6;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b1;

  // Register reset values and index width limit
  localparam logic [OFF_W-1:0]  OFFSET_RESET = 4'd4;
  localparam logic [IDXB_W-1:0] INDEX_RESET  = 5'd10;
  localparam logic [IDXB_W-1:0] MAX_IDX_BITS = 5'd16;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CAPACITY   = 2'd2,
    OUT_CONFLICT   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RECOUNT
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic lookup_rd;
    logic commit;
    logic recount_start;
    logic recount_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic recount_done;
  } dp_status_t;

endpackage

// ===== rtl/dmcmc_req_if.sv =====
interface dmcmc_req_if;
  logic                          valid;
  logic                          ready;
  logic [dmcmc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// ===== rtl/dmcmc_rsp_if.sv =====
interface dmcmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    outcome;
  logic [dmcmc_pkg::CNT_W-1:0]   hit_count;
  logic [dmcmc_pkg::CNT_W-1:0]   compulsory_count;
  logic [dmcmc_pkg::CNT_W-1:0]   capacity_count;
  logic [dmcmc_pkg::CNT_W-1:0]   conflict_count;

  modport source (output valid, output outcome, output hit_count, output compulsory_count,
                  output capacity_count, output conflict_count, input ready);
  modport sink   (input valid, input outcome, input hit_count, input compulsory_count,
                  input capacity_count, input conflict_count, output ready);
endinterface

// ===== rtl/dmcmc_ctrl.sv =====
module dmcmc_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dmcmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                               req_valid,
  output logic                               req_ready,
  output dmcmc_pkg::dp_cmd_t                 cmd,
  input  dmcmc_pkg::dp_status_t              status
);

  dmcmc_pkg::state_t state, state_next;
  logic              pending, pending_next;
  logic              idx_write;

  assign idx_write = cfg_we && (cfg_index == dmcmc_pkg::CFG_INDEX_BITS);
  assign req_ready = (state == dmcmc_pkg::ST_IDLE) && !pending;

  // State and pending recount flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dmcmc_pkg::ST_CLEAR;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      dmcmc_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = dmcmc_pkg::ST_IDLE;
      end
      dmcmc_pkg::ST_IDLE: begin
        if (pending) begin
          cmd.recount_start = 1'b1;
          state_next        = dmcmc_pkg::ST_RECOUNT;
        end else if (req_valid) begin
          cmd.lookup_rd = 1'b1;
          state_next    = dmcmc_pkg::ST_LOOKUP;
        end
      end
      dmcmc_pkg::ST_LOOKUP: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = dmcmc_pkg::ST_IDLE;
        end
      end
      dmcmc_pkg::ST_RECOUNT: begin
        if (idx_write) begin
          cmd.recount_start = 1'b1;
        end else begin
          cmd.recount_step = 1'b1;
          if (status.recount_done) state_next = dmcmc_pkg::ST_IDLE;
        end
      end
      default: state_next = dmcmc_pkg::ST_CLEAR;
    endcase
  end

  // Hold a recount request until the controller is free to run it
  always_comb begin
    pending_next = (pending && !cmd.recount_start) ||
                   (idx_write && (state == dmcmc_pkg::ST_IDLE ||
                                  state == dmcmc_pkg::ST_LOOKUP));
  end

endmodule

// ===== rtl/dmcmc_datapath.sv =====
module dmcmc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dmcmc_pkg::dp_cmd_t                  cmd,
  output dmcmc_pkg::dp_status_t               status,
  input  logic                                cfg_we,
  input  logic [dmcmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmcmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [dmcmc_pkg::ADDR_W-1:0]        address,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          outcome,
  output logic [dmcmc_pkg::CNT_W-1:0]         hit_count,
  output logic [dmcmc_pkg::CNT_W-1:0]         compulsory_count,
  output logic [dmcmc_pkg::CNT_W-1:0]         capacity_count,
  output logic [dmcmc_pkg::CNT_W-1:0]         conflict_count
);

  localparam int ADDR_W = dmcmc_pkg::ADDR_W;
  localparam int LINE_W = dmcmc_pkg::LINE_W;
  localparam int LCNT_W = dmcmc_pkg::LCNT_W;
  localparam int CNT_W  = dmcmc_pkg::CNT_W;

  logic [dmcmc_pkg::OFF_W-1:0]  offset_bits;
  logic [dmcmc_pkg::IDXB_W-1:0] index_bits;
  logic [dmcmc_pkg::IDXB_W-1:0] eff_ib;
  logic [LCNT_W-1:0]            lines;
  logic [LINE_W-1:0]            line_mask;
  logic [LINE_W-1:0]            idx_in;
  logic [ADDR_W-1:0]            tag_in;

  // Tag store: entry is {valid, tag}
  logic [ADDR_W:0]              mem [dmcmc_pkg::LINES];
  logic [ADDR_W:0]              rd_data;
  logic [LINE_W-1:0]            rd_addr;
  logic                         rd_en;
  logic [LINE_W-1:0]            wr_addr;
  logic [ADDR_W:0]              wr_data;
  logic                         wr_en;

  logic [LINE_W-1:0]            idx_q;
  logic [ADDR_W-1:0]            tag_q;
  logic [LCNT_W-1:0]            sweep;
  logic                         sweep_in_range;
  logic                         cnt_pend;
  logic [LCNT_W-1:0]            valid_lines;
  logic                         rd_valid;
  logic                         hit;
  dmcmc_pkg::outcome_t          outcome_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= dmcmc_pkg::OFFSET_RESET;
      index_bits  <= dmcmc_pkg::INDEX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmcmc_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data[dmcmc_pkg::OFF_W-1:0];
        dmcmc_pkg::CFG_INDEX_BITS:  index_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line count in use and address split
  assign eff_ib    = (index_bits > dmcmc_pkg::MAX_IDX_BITS) ? dmcmc_pkg::MAX_IDX_BITS
                                                             : index_bits;
  assign lines     = LCNT_W'(1) << eff_ib;
  assign line_mask = LINE_W'(lines - LCNT_W'(1));
  assign idx_in    = LINE_W'(address >> offset_bits) & line_mask;
  assign tag_in    = address >> (dmcmc_pkg::SHIFT_W'(offset_bits) +
                                 dmcmc_pkg::SHIFT_W'(eff_ib));

  assign sweep_in_range = sweep < lines;

  // Memory ports
  assign rd_en   = cmd.lookup_rd || (cmd.recount_step && sweep_in_range);
  assign rd_addr = cmd.lookup_rd ? idx_in : sweep[LINE_W-1:0];

  assign rd_valid = rd_data[ADDR_W];
  assign hit      = rd_valid && (rd_data[ADDR_W-1:0] == tag_q);

  assign wr_en   = cmd.clear_wr || (cmd.commit && !hit);
  assign wr_addr = cmd.clear_wr ? sweep[LINE_W-1:0] : idx_q;
  assign wr_data = cmd.clear_wr ? '0 : {1'b1, tag_q};

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Capture the request split for the compare cycle
  always_ff @(posedge clk) begin
    if (cmd.lookup_rd) begin
      idx_q <= idx_in;
      tag_q <= tag_in;
    end
  end

  // Classify the lookup
  always_comb begin
    if (hit)                  outcome_next = dmcmc_pkg::OUT_HIT;
    else if (valid_lines >= lines) outcome_next = dmcmc_pkg::OUT_CAPACITY;
    else if (rd_valid)        outcome_next = dmcmc_pkg::OUT_CONFLICT;
    else                      outcome_next = dmcmc_pkg::OUT_COMPULSORY;
  end

  // Sweep counter shared by the clearing pass and the recount
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      cnt_pend <= 1'b0;
    end else begin
      if (cmd.recount_start) sweep <= '0;
      else if (cmd.clear_wr || (cmd.recount_step && sweep_in_range)) sweep <= sweep + LCNT_W'(1);
      cnt_pend <= cmd.recount_step && sweep_in_range && !cmd.recount_start;
    end
  end

  // Valid line count
  always_ff @(posedge clk) begin
    if (rst || cmd.recount_start) begin
      valid_lines <= '0;
    end else if (cnt_pend && rd_valid) begin
      valid_lines <= valid_lines + LCNT_W'(1);
    end else if (cmd.commit && !rd_valid) begin
      valid_lines <= valid_lines + LCNT_W'(1);
    end
  end

  // Saturating outcome counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count        <= '0;
      compulsory_count <= '0;
      capacity_count   <= '0;
      conflict_count   <= '0;
    end else if (cmd.commit) begin
      case (outcome_next)
        dmcmc_pkg::OUT_HIT:
          if (hit_count != '1) hit_count <= hit_count + CNT_W'(1);
        dmcmc_pkg::OUT_COMPULSORY:
          if (compulsory_count != '1) compulsory_count <= compulsory_count + CNT_W'(1);
        dmcmc_pkg::OUT_CAPACITY:
          if (capacity_count != '1) capacity_count <= capacity_count + CNT_W'(1);
        dmcmc_pkg::OUT_CONFLICT:
          if (conflict_count != '1) conflict_count <= conflict_count + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) outcome <= outcome_next;
  end

  // Status to the controller
  assign status.clear_last   = (sweep[LINE_W-1:0] == '1);
  assign status.out_free     = !out_valid || out_ready;
  assign status.recount_done = !sweep_in_range && !cnt_pend;

endmodule

// ===== rtl/direct_mapped_cache_miss_classifier.sv =====
// Channel  Dir  Handshake       Payload
// req      in   valid / ready   address[25:0]
// rsp      out  valid / ready   outcome[1:0], hit/compulsory/capacity/conflict_count[31:0]
// cfg      in   cfg_we          cfg_index[0], cfg_data[4:0]
//
// In an access the accept cycle reads the tag store line; the compare step then
// checks the tag, writes the line back on a miss and loads the result register.
// The lookup waits in its compare cycle while the result register is still full.
// After reset a clearing pass writes all 65536 lines, one per cycle; req.ready is low.
// A write of index_bits outside clearing recounts valid lines in use; req.ready is low.
module direct_mapped_cache_miss_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmcmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmcmc_pkg::CFG_DATA_W-1:0] cfg_data,
  dmcmc_req_if.sink                        req,
  dmcmc_rsp_if.source                      rsp
);

  dmcmc_pkg::dp_cmd_t    cmd;
  dmcmc_pkg::dp_status_t status;

  dmcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .status    (status)
  );

  dmcmc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .address          (req.address),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .outcome          (rsp.outcome),
    .hit_count        (rsp.hit_count),
    .compulsory_count (rsp.compulsory_count),
    .capacity_count   (rsp.capacity_count),
    .conflict_count   (rsp.conflict_count)
  );

endmodule

// ===== rtl/dmcmc_checker.sv =====
module dmcmc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [1:0]                     rsp_outcome,
  input logic [dmcmc_pkg::CNT_W-1:0]    hit_count
);

  // A result held back by the sink stays put
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(hit_count))
    else $error("result dropped or changed while stalled");

  // The clearing pass blocks requests right after reset
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // One request at a time: no accept in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("back-to-back request accepted");

  // A reported hit has been counted
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_outcome == dmcmc_pkg::OUT_HIT) |-> hit_count != '0)
    else $error("hit reported with zero hit count");

endmodule

bind direct_mapped_cache_miss_classifier dmcmc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_outcome (rsp.outcome),
  .hit_count   (rsp.hit_count)
);

// ===== dv/direct_mapped_cache_miss_classifier_tb.sv =====
`timescale 1ns / 1ps

module direct_mapped_cache_miss_classifier_tb;

  localparam int ADDR_W     = dmcmc_pkg::ADDR_W;
  localparam int CNT_W      = dmcmc_pkg::CNT_W;
  localparam int CFG_IDX_W  = dmcmc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = dmcmc_pkg::CFG_DATA_W;
  localparam int OFF_W      = dmcmc_pkg::OFF_W;
  localparam int IDXB_W     = dmcmc_pkg::IDXB_W;
  localparam int LINES      = dmcmc_pkg::LINES;

  localparam int unsigned ACCESS_TARGET = 1450;
  localparam int unsigned STALL_LIMIT   = 300000;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned MAX_BIG_RECOUNTS = 2;

  typedef struct {
    dmcmc_pkg::outcome_t outcome;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   compulsory;
    logic [CNT_W-1:0]   capacity;
    logic [CNT_W-1:0]   conflict;
  } access_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dmcmc_req_if req_ch ();
  dmcmc_rsp_if rsp_ch ();

  direct_mapped_cache_miss_classifier uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the tag store, valid bits, registers and tallies
  logic [ADDR_W-1:0] shadow_tag [LINES];
  bit                shadow_valid [LINES];
  logic [OFF_W-1:0]  shadow_offset;
  logic [IDXB_W-1:0] shadow_index;
  int unsigned       shadow_valid_lines;
  logic [CNT_W-1:0]  tally_hit, tally_compulsory, tally_capacity, tally_conflict;

  access_verdict_t pending_verdicts [$];

  bit          sender_idles;
  bit          receiver_stalls;
  int unsigned mismatches;
  int unsigned accesses_sent;
  int unsigned random_phases;
  int unsigned outcome_seen [4];
  int unsigned quiet_cycles;

  function automatic int unsigned index_width_used();
    return (shadow_index > dmcmc_pkg::MAX_IDX_BITS) ? int'(dmcmc_pkg::MAX_IDX_BITS)
                                                    : int'(shadow_index);
  endfunction

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
    end
    shadow_offset      = dmcmc_pkg::OFFSET_RESET;
    shadow_index       = dmcmc_pkg::INDEX_RESET;
    shadow_valid_lines = 0;
    tally_hit          = '0;
    tally_compulsory   = '0;
    tally_capacity     = '0;
    tally_conflict     = '0;
  endfunction

  // Recount valid lines over the lines now in use
  function automatic void recount_valid_lines();
    int unsigned lines_used;
    lines_used = 1 << index_width_used();
    shadow_valid_lines = 0;
    for (int unsigned i = 0; i < lines_used; i++)
      if (shadow_valid[i]) shadow_valid_lines++;
  endfunction

  // Look up one address, update the shadow state, return the expected result
  function automatic access_verdict_t classify_access(input logic [ADDR_W-1:0] a);
    int unsigned     ib, lines_used, off, line;
    logic [63:0]     wide;
    logic [ADDR_W-1:0] tag;
    access_verdict_t v;
    ib         = index_width_used();
    lines_used = 1 << ib;
    off        = shadow_offset;
    wide       = {{(64-ADDR_W){1'b0}}, a};
    line       = int'((wide >> off) & 64'(lines_used - 1));
    tag        = ADDR_W'(wide >> (off + ib));
    if (shadow_valid[line] && shadow_tag[line] == tag) begin
      v.outcome = dmcmc_pkg::OUT_HIT;
      tally_hit = sat_bump(tally_hit);
    end else begin
      shadow_tag[line] = tag;
      if (shadow_valid_lines >= lines_used) begin
        v.outcome      = dmcmc_pkg::OUT_CAPACITY;
        tally_capacity = sat_bump(tally_capacity);
      end else if (shadow_valid[line]) begin
        v.outcome      = dmcmc_pkg::OUT_CONFLICT;
        tally_conflict = sat_bump(tally_conflict);
      end else begin
        v.outcome        = dmcmc_pkg::OUT_COMPULSORY;
        tally_compulsory = sat_bump(tally_compulsory);
      end
      if (!shadow_valid[line]) begin
        shadow_valid[line] = 1'b1;
        shadow_valid_lines++;
      end
    end
    v.hits       = tally_hit;
    v.compulsory = tally_compulsory;
    v.capacity   = tally_capacity;
    v.conflict   = tally_conflict;
    return v;
  endfunction

  function automatic int field_differs(input string label, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Check each accepted result against the oldest expected one
  always @(posedge clk) begin : check_result
    access_verdict_t want;
    int              bad;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result: expected none actual outcome %0d",
                 $time, rsp_ch.outcome);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        outcome_seen[want.outcome]++;
        bad = field_differs("outcome", CNT_W'(want.outcome), CNT_W'(rsp_ch.outcome));
        bad += field_differs("hit_count", want.hits, rsp_ch.hit_count);
        bad += field_differs("compulsory_count", want.compulsory, rsp_ch.compulsory_count);
        bad += field_differs("capacity_count", want.capacity, rsp_ch.capacity_count);
        bad += field_differs("conflict_count", want.conflict, rsp_ch.conflict_count);
        if (bad != 0) mismatches++;
      end
    end
  end

  // Drive result ready, with a random stall before each result while receiver_stalls is set
  initial begin : drive_rsp_ready
    int unsigned wait_cycles;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      wait_cycles = receiver_stalls ? $urandom_range(0, 19) : 0;
      if (wait_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || cfg_we === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request; hold valid when the next one follows at once
  task automatic send_access(input logic [ADDR_W-1:0] a);
    int unsigned gap;
    req_ch.valid   <= 1'b1;
    req_ch.address <= a;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_verdicts.push_back(classify_access(a));
    accesses_sent++;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle_traffic();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register while idle, then wait for the block to accept requests
  task automatic write_register(input logic [CFG_IDX_W-1:0] which,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == dmcmc_pkg::CFG_OFFSET_BITS) begin
      shadow_offset = value[OFF_W-1:0];
    end else begin
      shadow_index = value;
      recount_valid_lines();
    end
    repeat (3) @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic apply_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold until the clearing pass has finished
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Reset register values: compulsory, hit in block, far line, then conflicts
  task automatic test_reset_defaults();
    send_access('0);
    send_access(ADDR_W'(26'h000000F));
    send_access('1);
    send_access(ADDR_W'(26'h0004000));
    send_access('0);
    settle_traffic();
  endtask

  // One and two lines in use: every miss to a full cache is a capacity miss
  task automatic test_single_line_capacity();
    write_register(dmcmc_pkg::CFG_OFFSET_BITS, CFG_DATA_W'(0));
    write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(0));
    send_access(ADDR_W'(7));
    send_access(ADDR_W'(7));
    send_access('1);
    settle_traffic();
    write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(1));
    send_access(ADDR_W'(1));
    send_access(ADDR_W'(3));
    send_access(ADDR_W'(2));
    settle_traffic();
  endtask

  // Widest offset and index, index above its limit, and the offset range edge
  task automatic test_field_extremes();
    write_register(dmcmc_pkg::CFG_OFFSET_BITS, CFG_DATA_W'(5'h1F));
    write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(5'h1F));
    send_access('0);
    send_access('1);
    send_access(ADDR_W'(26'h2AAAAAA));
    send_access(ADDR_W'(26'h1555555));
    send_access('1);
    settle_traffic();
    write_register(dmcmc_pkg::CFG_OFFSET_BITS, CFG_DATA_W'(0));
    write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(16));
    send_access('1);
    send_access(ADDR_W'(26'h000FFFF));
    send_access('1);
    send_access('0);
    settle_traffic();
    write_register(dmcmc_pkg::CFG_OFFSET_BITS, CFG_DATA_W'(12));
    write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(2));
    send_access(ADDR_W'(26'h0003000));
    send_access(ADDR_W'(26'h0007FFF));
    send_access(ADDR_W'(26'h0003ABC));
    settle_traffic();
  endtask

  // Random configurations, each with a burst of mostly local traffic
  task automatic test_random_traffic();
    int unsigned       big_left, pick, offv, idxv, ib, lines_used;
    int unsigned       pool_size, win, base, phase_len;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0] tag_pool [4];
    logic [63:0]       wide;
    big_left = MAX_BIG_RECOUNTS;
    while (accesses_sent < ACCESS_TARGET) begin
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      offv = $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        idxv = $urandom_range(0, 5);
      end else if (pick < 92 || big_left == 0) begin
        idxv = $urandom_range(6, 12);
      end else begin
        idxv = $urandom_range(13, 31);
        big_left--;
      end
      data    = CFG_DATA_W'(offv);
      data[4] = $urandom_range(0, 1);
      write_register(dmcmc_pkg::CFG_OFFSET_BITS, data);
      write_register(dmcmc_pkg::CFG_INDEX_BITS, CFG_DATA_W'(idxv));

      ib         = index_width_used();
      lines_used = 1 << ib;
      pool_size  = $urandom_range(1, 4);
      foreach (tag_pool[k]) tag_pool[k] = ADDR_W'($urandom);
      win        = $urandom_range(1, 8);
      base       = $urandom_range(0, lines_used - 1);
      phase_len  = $urandom_range(30, 90);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          wide = (64'(tag_pool[$urandom_range(0, pool_size - 1)]) << (offv + ib))
               | (64'((base + $urandom_range(0, win - 1)) & (lines_used - 1)) << offv)
               | (64'($urandom) & ((64'd1 << offv) - 1));
          send_access(wide[ADDR_W-1:0]);
        end else begin
          send_access(ADDR_W'($urandom));
        end
        // Pause now and then until the block has answered everything
        if ($urandom_range(0, 99) == 0) settle_traffic();
      end
      settle_traffic();
      random_phases++;
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= dmcmc_pkg::CFG_OFFSET_BITS;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.address <= '0;
    reset_shadow();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    mismatches      = 0;
    accesses_sent   = 0;
    random_phases   = 0;
    foreach (outcome_seen[k]) outcome_seen[k] = 0;

    apply_reset();
    test_reset_defaults();
    test_single_line_capacity();
    test_field_extremes();
    test_random_traffic();

    settle_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: results missing: expected %0d more actual 0",
               $time, pending_verdicts.size());
      mismatches++;
    end

    $display("Ran %0d accesses: directed cases plus %0d random cache geometries",
             accesses_sent, random_phases);
    $display("Outcomes: %0d hit, %0d compulsory, %0d capacity, %0d conflict; %0d bad results",
             outcome_seen[dmcmc_pkg::OUT_HIT], outcome_seen[dmcmc_pkg::OUT_COMPULSORY],
             outcome_seen[dmcmc_pkg::OUT_CAPACITY], outcome_seen[dmcmc_pkg::OUT_CONFLICT],
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
